// File: design/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg: shared types and constants of the interval rank comparator
// fixed-point format defaults, kind and method codes, config addresses
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int unsigned ValueWidthDef    = 32;
  localparam int unsigned FractionBitsDef  = 16;
  localparam int unsigned TolWidth         = 16;
  localparam int unsigned KindWidth        = 4;
  localparam int unsigned CmpMethodWidth   = 3;
  localparam int unsigned SelMethodWidth   = 2;
  localparam int unsigned PaddrWidth       = 4;
  localparam int unsigned PdataWidth       = 32;

  typedef enum logic [KindWidth-1:0] {
    KIND_EQ  = 4'd0,
    KIND_GT  = 4'd1,
    KIND_GE  = 4'd2,
    KIND_LT  = 4'd3,
    KIND_LE  = 4'd4,
    KIND_EQL = 4'd5,
    KIND_EQU = 4'd6,
    KIND_MAX = 4'd7,
    KIND_MIN = 4'd8
  } kind_e;

  typedef enum logic [CmpMethodWidth-1:0] {
    METH_COMP  = 3'd0,
    METH_MID   = 3'd1,
    METH_MIDW  = 3'd2,
    METH_PROB  = 3'd3,
    METH_LEXL  = 3'd4,
    METH_LEXU  = 3'd5,
    METH_SUMW  = 3'd6,
    METH_COMP7 = 3'd7
  } method_e;

  typedef enum logic [PaddrWidth-1:0] {
    ADDR_CMP_METHOD = 4'h0,
    ADDR_SEL_METHOD = 4'h4,
    ADDR_EQUAL_TOL  = 4'h8
  } addr_e;

  // three-way compare facts, each as greater / equal flags
  typedef struct packed {
    logic ca_gt, ca_eq;
    logic cb_gt, cb_eq;
    logic cm_gt, cm_eq;
    logic cw_gt, cw_eq;
    logic cs_gt, cs_eq;
  } facts_t;

endpackage

// File: design/irc_if.sv
// ----------------------------------------------------------------------------
// irc_if: valid/ready channel carrying one payload
// source drives valid and payload, sink drives ready
// ----------------------------------------------------------------------------
interface irc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/irc_div.sv
// ----------------------------------------------------------------------------
// irc_div: pipelined restoring divider for the probability ratio
// one quotient bit per stage, clamp and rounding done by the caller
// ----------------------------------------------------------------------------
module irc_div #(
  parameter int unsigned W     = 130,
  parameter int unsigned QBITS = 17,
  parameter int unsigned TW    = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [W-1:0]    num_i,
  input  logic [W-1:0]    den_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [QBITS-1:0] quo_o,
  output logic [TW-1:0]   tag_o
);
  logic [W-1:0]     rem_q [QBITS+1];
  logic [W-1:0]     den_q [QBITS+1];
  logic [QBITS-1:0] quo_q [QBITS+1];
  logic [TW-1:0]    tag_q [QBITS+1];
  logic             vld_q [QBITS+1];

  always_comb begin
    rem_q[0] = num_i;
    den_q[0] = den_i;
    quo_q[0] = '0;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [W-1:0] sh_d;
    logic         ge_d;
    assign sh_d = {rem_q[s][W-2:0], 1'b0};
    assign ge_d = sh_d >= den_q[s];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge_d ? sh_d - den_q[s] : sh_d;
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= {quo_q[s][QBITS-2:0], ge_d};
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[QBITS];
  assign quo_o   = quo_q[QBITS];
  assign tag_o   = tag_q[QBITS];
endmodule

// File: design/interval_rank_compare_top.sv
// ----------------------------------------------------------------------------
// interval_rank_compare_top: ranks two signed fixed-point intervals
//
// channel   dir   payload
// req_in    in    kind, first_low, first_high, second_low, second_high
// rsp_out   out   relation_true, result_low, result_high,
//                 lower_probability, divide_fault
// apb       in    compare_method, select_method, equal_tolerance
//
// one request per cycle while rsp_out is not stalled; the pipeline runs through
// the difference, product and numerator stages, the bit-per-stage divider and the output register.
// rst_ni clears all valid bits and loads the register reset values.
// a stall on rsp_out freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module interval_rank_compare_top #(
  parameter int unsigned VALUE_WIDTH   = irc_pkg::ValueWidthDef,
  parameter int unsigned FRACTION_BITS = irc_pkg::FractionBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  irc_if.sink   req_in,
  irc_if.source rsp_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irc_pkg::PaddrWidth-1:0] paddr,
  input  logic [irc_pkg::PdataWidth-1:0] pwdata,
  output logic [irc_pkg::PdataWidth-1:0] prdata,
  output logic                          pready
);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned EW = VW + 2;          // differences and sums
  localparam int unsigned MW = 2 * EW + 2;      // products and their sums
  localparam int unsigned QB = FRACTION_BITS + 1;
  localparam int unsigned PW = FRACTION_BITS + 1;
  localparam logic [PW-1:0] POne  = PW'(1) << FRACTION_BITS;
  localparam logic [PW-1:0] PHalf = PW'(1) << (FRACTION_BITS - 1);

  // ---- configuration
  logic [irc_pkg::CmpMethodWidth-1:0] cmp_meth_q;
  logic [irc_pkg::SelMethodWidth-1:0] sel_meth_q;
  logic [irc_pkg::TolWidth-1:0]       tol_q;
  logic                               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_meth_q <= '0;
      sel_meth_q <= '0;
      tol_q      <= irc_pkg::TolWidth'(1);
    end else if (wr_en) begin
      case (paddr)
        irc_pkg::ADDR_CMP_METHOD: cmp_meth_q <= pwdata[irc_pkg::CmpMethodWidth-1:0];
        irc_pkg::ADDR_SEL_METHOD: sel_meth_q <= pwdata[irc_pkg::SelMethodWidth-1:0];
        irc_pkg::ADDR_EQUAL_TOL:  tol_q      <= pwdata[irc_pkg::TolWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      irc_pkg::ADDR_CMP_METHOD: prdata = irc_pkg::PdataWidth'(cmp_meth_q);
      irc_pkg::ADDR_SEL_METHOD: prdata = irc_pkg::PdataWidth'(sel_meth_q);
      irc_pkg::ADDR_EQUAL_TOL:  prdata = irc_pkg::PdataWidth'(tol_q);
      default:                  prdata = '0;
    endcase
  end

  // ---- pipeline control: global enable, output skid-free hold
  logic en;
  logic out_vld_q;
  assign en           = !out_vld_q || rsp_out.ready;
  assign req_in.ready = en;

  // ---- stage 1: differences and compare facts
  logic                 v1_q;
  logic [3:0]           kind1_q;
  logic signed [EW-1:0] a1_q, b1_q, a2_q, b2_q;
  irc_pkg::facts_t      f1_q;
  logic [5:0]           pc1_q; // probability-case compare flags
  logic signed [EW-1:0] tol_e;
  logic signed [EW-1:0] a1_d, b1_d, a2_d, b2_d;
  irc_pkg::facts_t      f_d;
  logic [5:0]           pc_d;

  assign tol_e = EW'(tol_q);
  assign a1_d  = EW'(signed'(req_in.payload.first_low));
  assign b1_d  = EW'(signed'(req_in.payload.first_high));
  assign a2_d  = EW'(signed'(req_in.payload.second_low));
  assign b2_d  = EW'(signed'(req_in.payload.second_high));

  function automatic logic [1:0] tcmp(input logic signed [EW-1:0] x,
                                      input logic signed [EW-1:0] y,
                                      input logic signed [EW-1:0] t);
    logic signed [EW-1:0] d;
    d = x - y;
    tcmp = {d > t, (d <= t) && (d >= -t)};
  endfunction

  logic [1:0] c_a1b2, c_b1a2, c_a2a1, c_b2b1, c_b1b2;
  always_comb begin
    {f_d.ca_gt, f_d.ca_eq} = tcmp(a1_d, a2_d, tol_e);
    {f_d.cb_gt, f_d.cb_eq} = tcmp(b1_d, b2_d, tol_e);
    {f_d.cm_gt, f_d.cm_eq} = tcmp(a1_d + b1_d, a2_d + b2_d, tol_e <<< 1);
    {f_d.cs_gt, f_d.cs_eq} = tcmp(a1_d + b1_d, a2_d + b2_d, tol_e);
    {f_d.cw_gt, f_d.cw_eq} = tcmp(b1_d - a1_d, b2_d - a2_d, tol_e);
    c_a1b2 = tcmp(a1_d, b2_d, tol_e);
    c_b1a2 = tcmp(b1_d, a2_d, tol_e);
    c_a2a1 = tcmp(a2_d, a1_d, tol_e);
    c_b2b1 = tcmp(b2_d, b1_d, tol_e);
    c_b1b2 = tcmp(b1_d, b2_d, tol_e);
    pc_d[0] = c_a1b2[1] || c_a1b2[0];     // p = 0
    pc_d[1] = !c_b1a2[1];                 // p = 1
    pc_d[2] = !c_a2a1[1];                 // a2 <= a1
    pc_d[3] = !c_b2b1[1];                 // b2 <= b1
    pc_d[4] = !c_b1b2[1] && !c_b1b2[0];   // b1 < b2
    pc_d[5] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= req_in.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= req_in.payload.kind;
      a1_q <= a1_d; b1_q <= b1_d; a2_q <= a2_d; b2_q <= b2_d;
      f1_q <= f_d;  pc1_q <= pc_d;
    end
  end

  // ---- stage 2: products
  logic                 v2_q;
  logic [3:0]           kind2_q;
  logic signed [EW-1:0] a12_q, b12_q, a22_q, b22_q;
  irc_pkg::facts_t      f2_q;
  logic [5:0]           pc2_q;
  logic signed [MW-1:0] p_lalb_q, p_x_q, p_y_q, p_z_q;
  logic signed [EW-1:0] la, lb;
  logic signed [MW-1:0] x_d, y_d, z_d;

  assign la = b1_q - a1_q;
  assign lb = b2_q - a2_q;
  always_comb begin
    if (pc1_q[2]) begin
      x_d = MW'(b2_q - a1_q) * MW'(b2_q - a1_q);
      y_d = '0;
      z_d = '0;
    end else begin
      x_d = MW'(a2_q - a1_q) * MW'(lb);
      y_d = MW'(b1_q - a2_q) * MW'(b2_q - b1_q);
      z_d = MW'(b1_q - a2_q) * MW'(b1_q - a2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind2_q <= kind1_q; f2_q <= f1_q; pc2_q <= pc1_q;
      a12_q <= a1_q; b12_q <= b1_q; a22_q <= a2_q; b22_q <= b2_q;
      p_lalb_q <= MW'(la) * MW'(lb);
      p_x_q <= x_d; p_y_q <= y_d; p_z_q <= z_d;
    end
  end

  // ---- stage 3: numerator, denominator, sign normalize, clamp flags
  localparam int unsigned TW = 4 + $bits(irc_pkg::facts_t) + 3 + 4 * VW;
  logic                 v3_q;
  logic [MW-1:0]        num3_q, den3_q;
  logic [TW-1:0]        tag3_q;
  logic signed [MW-1:0] n_d, d_d, nn, dn;
  logic                 fz_d, pzero_d, pone_d;

  always_comb begin
    if (pc2_q[2]) begin
      if (pc2_q[3]) begin
        n_d = p_x_q;
        d_d = p_lalb_q <<< 1;
      end else begin
        n_d = (MW'(b22_q - b12_q) <<< 1) + MW'(b12_q - a12_q);
        d_d = MW'(b22_q - a22_q) <<< 1;
      end
    end else if (pc2_q[4]) begin
      n_d = (p_x_q <<< 1) + (p_y_q <<< 1) + p_z_q;
      d_d = p_lalb_q <<< 1;
    end else begin
      n_d = (MW'(a22_q - a12_q) <<< 1) + MW'(b22_q - a22_q);
      d_d = MW'(b12_q - a12_q) <<< 1;
    end
    nn = d_d[MW-1] ? -n_d : n_d;
    dn = d_d[MW-1] ? -d_d : d_d;
    fz_d    = !pc2_q[0] && !pc2_q[1] && (d_d == '0);
    pzero_d = pc2_q[0] || (!pc2_q[1] && nn[MW-1]);
    pone_d  = !pc2_q[0] && (pc2_q[1] || (!nn[MW-1] && nn >= dn));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      num3_q <= (pzero_d || pone_d || fz_d) ? '0 : nn;
      den3_q <= (pzero_d || pone_d || fz_d) ? MW'(1) : dn;
      tag3_q <= {kind2_q, f2_q, fz_d, pzero_d, pone_d,
                 VW'(a12_q), VW'(b12_q), VW'(a22_q), VW'(b22_q)};
    end
  end

  // ---- divider stages
  logic          vq;
  logic [QB-1:0] quo;
  logic [TW-1:0] tagq;

  irc_div #(.W(MW), .QBITS(QB), .TW(TW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q),
    .num_i(num3_q), .den_i(den3_q), .tag_i(tag3_q),
    .valid_o(vq), .quo_o(quo), .tag_o(tagq)
  );

  // ---- final stage: decision and output register
  logic [3:0]            k;
  irc_pkg::facts_t       f;
  logic                  fz, pz, po;
  logic signed [VW-1:0]  a1, b1, a2, b2;
  logic [PW-1:0]         p;
  logic                  rel, first;
  logic signed [VW-1:0]  rl, rh;

  assign {k, f, fz, pz, po, a1, b1, a2, b2} = tagq;

  function automatic logic relate(input logic [1:0] op, input logic [2:0] m,
                                  input irc_pkg::facts_t ff,
                                  input logic [PW-1:0] pp, input logic flt);
    logic r;
    case (irc_pkg::method_e'(m))
      irc_pkg::METH_MID:
        r = (op == 2'd0) ? ff.cm_eq : (op == 2'd1) ? ff.cm_gt : ff.cm_gt || ff.cm_eq;
      irc_pkg::METH_MIDW:
        r = (op == 2'd0) ? ff.cm_eq && ff.cw_eq :
            ff.cm_gt || (ff.cm_eq && (ff.cw_gt || (op == 2'd2 && ff.cw_eq)));
      irc_pkg::METH_PROB:
        r = !flt && ((op == 2'd0) ? pp == PHalf : (op == 2'd1) ? pp < PHalf : pp <= PHalf);
      irc_pkg::METH_LEXL:
        r = (op == 2'd0) ? ff.ca_eq && ff.cb_eq :
            ff.ca_gt || (ff.ca_eq && (ff.cb_gt || (op == 2'd2 && ff.cb_eq)));
      irc_pkg::METH_LEXU:
        r = (op == 2'd0) ? ff.ca_eq && ff.cb_eq :
            ff.cb_gt || (ff.cb_eq && (ff.ca_gt || (op == 2'd2 && ff.ca_eq)));
      irc_pkg::METH_SUMW:
        r = (op == 2'd0) ? ff.cs_eq && ff.cw_eq :
            ff.cs_gt || (ff.cs_eq && (ff.cw_gt || (op == 2'd2 && ff.cw_eq)));
      default:
        r = (op == 2'd0) ? ff.ca_eq && ff.cb_eq : (op == 2'd1) ? ff.ca_gt && ff.cb_gt :
            (ff.ca_gt || ff.ca_eq) && (ff.cb_gt || ff.cb_eq);
    endcase
    return r;
  endfunction

  always_comb begin
    if (fz || pz)   p = '0;
    else if (po)    p = POne;
    else            p = PW'(({1'b0, quo} + (QB + 1)'(1)) >> 1);
    rel   = 1'b0;
    rl    = '0;
    rh    = '0;
    first = 1'b0;
    case (k)
      irc_pkg::KIND_EQ:  rel = relate(2'd0, cmp_meth_q, f, p, fz);
      irc_pkg::KIND_GT:  rel = relate(2'd1, cmp_meth_q, f, p, fz);
      irc_pkg::KIND_GE:  rel = relate(2'd2, cmp_meth_q, f, p, fz);
      irc_pkg::KIND_LT:  rel = !relate(2'd2, cmp_meth_q, f, p, fz);
      irc_pkg::KIND_LE:  rel = !relate(2'd1, cmp_meth_q, f, p, fz);
      irc_pkg::KIND_EQL: rel = f.ca_eq;
      irc_pkg::KIND_EQU: rel = f.cb_eq;
      irc_pkg::KIND_MAX, irc_pkg::KIND_MIN: begin
        if (sel_meth_q == '0) begin
          if (k == irc_pkg::KIND_MAX) begin
            rl  = (a1 > a2) ? a1 : a2;
            rh  = (b1 > b2) ? b1 : b2;
            rel = (a1 >= a2) && (b1 >= b2);
          end else begin
            rl  = (a1 < a2) ? a1 : a2;
            rh  = (b1 < b2) ? b1 : b2;
            rel = (a1 <= a2) && (b1 <= b2);
          end
        end else begin
          if (sel_meth_q == 2'd3 && fz) first = 1'b0;
          else if (k == irc_pkg::KIND_MAX)
            first = relate(2'd1, {1'b0, sel_meth_q}, f, p, fz);
          else
            first = !relate(2'd2, {1'b0, sel_meth_q}, f, p, fz);
          rel = first;
          rl  = first ? a1 : a2;
          rh  = first ? b1 : b2;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vq;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_out.payload.relation_true     <= rel;
      rsp_out.payload.result_low        <= rl;
      rsp_out.payload.result_high       <= rh;
      rsp_out.payload.lower_probability <= p;
      rsp_out.payload.divide_fault      <= fz;
    end
  end
  assign rsp_out.valid = out_vld_q;
endmodule

// File: design/irc_checker.sv
// ----------------------------------------------------------------------------
// irc_checker: port-level checks of the interval rank comparator
// bound to the top level
// ----------------------------------------------------------------------------
module irc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        in_ready,
  input logic        rel,
  input logic        fault,
  input logic [16:0] prob
);
  a_fault_zero_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && fault |-> prob == '0) else $error("fault with nonzero p");
  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> prob <= 17'h10000) else $error("p above one");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(rel)) else $error("output dropped");
endmodule

bind interval_rank_compare_top irc_checker u_irc_checker (
  .clk_i, .rst_ni,
  .out_valid(rsp_out.valid), .out_ready(rsp_out.ready), .in_ready(req_in.ready),
  .rel(rsp_out.payload.relation_true), .fault(rsp_out.payload.divide_fault),
  .prob(rsp_out.payload.lower_probability)
);
